FILE: rtl/a2c_pkg.sv
// Shared types and constants for the alignment-to-CIGAR encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package a2c_pkg;

  // Width of the internal run counter; runs saturate at its all-ones value.
  localparam int LENGTH_BITS = 16;
  // Width of the emitted length field, which also carries the clip lengths.
  localparam int RUN_W = 16;
  localparam int OP_W = 3;
  // Up to three operations come out of one column.
  localparam int NUM_SLOTS = 3;
  localparam int SLOT_W = $clog2(NUM_SLOTS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_M = 3'd0,
    OP_I = 3'd1,
    OP_D = 3'd2,
    OP_S = 3'd3,
    OP_H = 3'd4
  } op_t;

  typedef struct packed {
    logic                 valid;
    op_t                  op;
    logic [RUN_W-1:0]     len;
    logic                 eoc;
  } entry_t;

  // One column's worth of operations, in output order: slot 0 is the leading
  // clip or the broken run, slot 1 the closing run, slot 2 the trailing clip.
  typedef entry_t [NUM_SLOTS-1:0] rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

`default_nettype wire

FILE: rtl/a2c_front.sv
// Front end: takes alignment columns, tracks the open run and builds the
// record of operations each column produces. Depends on a2c_pkg.
`default_nettype none

module a2c_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic                  cfg_data,
  input  wire logic                  take,
  input  wire logic                  query_gap,
  input  wire logic                  ref_gap,
  input  wire logic                  first_column,
  input  wire logic                  last_column,
  input  wire logic [15:0]           lead_clip,
  input  wire logic [15:0]           trail_clip,
  output a2c_pkg::rec_t              rec,
  output logic                       rec_push
);
  import a2c_pkg::*;

  logic                   clip_as_hard;
  op_t                    current_op;
  logic [LENGTH_BITS-1:0] current_length;
  logic                   run_open;

  op_t                    clip_op;
  op_t                    new_op;
  op_t                    op_next;
  logic [LENGTH_BITS-1:0] length_next;
  logic                   eff_open;
  logic                   cont;

  always_comb begin
    clip_op  = clip_as_hard ? OP_H : OP_S;
    new_op   = query_gap ? OP_D : (ref_gap ? OP_I : OP_M);
    // A first column drops whatever run was left open.
    eff_open = run_open & ~first_column;
    unique case (current_op)
      OP_D:    cont = eff_open & query_gap;
      OP_I:    cont = eff_open & ref_gap;
      default: cont = eff_open & ~query_gap & ~ref_gap;
    endcase
    if (cont) begin
      op_next     = current_op;
      length_next = (current_length == '1) ? current_length
                                           : current_length + 1'b1;
    end else begin
      op_next     = new_op;
      length_next = LENGTH_BITS'(1);
    end

    rec = '0;
    if (first_column) begin
      rec[0].valid = (lead_clip != '0);
      rec[0].op    = clip_op;
      rec[0].len   = lead_clip;
    end else begin
      rec[0].valid = eff_open & ~cont;
      rec[0].op    = current_op;
      rec[0].len   = RUN_W'(current_length);
    end
    rec[0].eoc   = 1'b0;
    rec[1].valid = last_column;
    rec[1].op    = op_next;
    rec[1].len   = RUN_W'(length_next);
    rec[1].eoc   = (trail_clip == '0);
    rec[2].valid = last_column & (trail_clip != '0);
    rec[2].op    = clip_op;
    rec[2].len   = trail_clip;
    rec[2].eoc   = 1'b1;

    // Columns that only extend a run produce nothing to queue.
    rec_push = take & (rec[0].valid | rec[1].valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_as_hard   <= 1'b0;
      current_op     <= OP_M;
      current_length <= '0;
      run_open       <= 1'b0;
    end else begin
      if (cfg_write) begin
        clip_as_hard <= cfg_data;
      end
      if (take) begin
        current_op <= op_next;
        if (last_column) begin
          run_open       <= 1'b0;
          current_length <= '0;
        end else begin
          run_open       <= 1'b1;
          current_length <= length_next;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/a2c_queue.sv
// Short record queue between the front and back ends.
// Depends on a2c_pkg.
`default_nettype none

module a2c_queue (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  input  wire a2c_pkg::rec_t         push_rec,
  input  wire logic                  pop,
  output a2c_pkg::rec_t              head_rec,
  output a2c_pkg::q_status_t         status
);
  import a2c_pkg::*;

  rec_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  always_comb begin
    status.full  = (count == QCNT_W'(QUEUE_DEPTH));
    status.empty = (count == '0);
    do_push      = push & ~status.full;
    do_pop       = pop & ~status.empty;
    head_rec     = mem[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/a2c_back.sv
// Back end: walks the valid slots of the head record and emits one CIGAR
// operation per beat through an output register. Depends on a2c_pkg.
`default_nettype none

module a2c_back (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire a2c_pkg::rec_t         head_rec,
  input  wire a2c_pkg::q_status_t    status,
  output logic                       pop,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [a2c_pkg::OP_W-1:0]   op_code,
  output logic [a2c_pkg::RUN_W-1:0]  run_length,
  output logic                       end_of_cigar
);
  import a2c_pkg::*;

  logic [NUM_SLOTS-1:0] done;
  logic [NUM_SLOTS-1:0] pend;
  logic [NUM_SLOTS-1:0] sel_bit;
  logic [SLOT_W-1:0]    sel;
  logic                 load;
  entry_t               ent;

  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      pend[i] = head_rec[i].valid & ~done[i];
    end
    // Lowest pending slot goes first.
    sel = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (pend[i]) begin
        sel = SLOT_W'(i);
      end
    end
    sel_bit = NUM_SLOTS'(1) << sel;
    ent     = head_rec[sel];
    load    = ~status.empty & (~out_valid | ~out_stall);
    pop     = load & ((pend & ~sel_bit) == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        done      <= pop ? '0 : (done | sel_bit);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      op_code      <= ent.op;
      run_length   <= ent.len;
      end_of_cigar <= ent.eoc;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/alignment_to_cigar_encoder_top.sv
// Top level of the alignment-to-CIGAR encoder: front end, record queue and
// back end. Depends on a2c_pkg, a2c_front, a2c_queue and a2c_back.
`default_nettype none

// Run-length codes a stream of alignment columns into CIGAR operations. One
// column is taken per cycle while the two-record queue has room; a column
// that extends a run is taken and queues nothing. The output side delivers
// one operation per cycle when not stalled, so a column that closes a run,
// ends the alignment or carries a clip uses the output once per operation it
// makes (one to three); sustained throughput is set by that single output.
// Clip type is set by the cfg port (data bit 1 = H, 0 = S); cfg_ready is
// always high, and writes are meant for idle periods only.
module alignment_to_cigar_encoder_top (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  query_gap,
  input  wire logic                  ref_gap,
  input  wire logic                  first_column,
  input  wire logic                  last_column,
  input  wire logic [15:0]           lead_clip,
  input  wire logic [15:0]           trail_clip,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [a2c_pkg::OP_W-1:0]   op_code,
  output logic [a2c_pkg::RUN_W-1:0]  run_length,
  output logic                       end_of_cigar
);
  import a2c_pkg::*;

  rec_t      rec;
  rec_t      head_rec;
  q_status_t status;
  logic      rec_push;
  logic      pop;
  logic      take;

  assign cfg_ready = 1'b1;
  assign in_stall  = status.full;
  assign take      = in_valid & ~status.full;

  a2c_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .take         (take),
    .query_gap    (query_gap),
    .ref_gap      (ref_gap),
    .first_column (first_column),
    .last_column  (last_column),
    .lead_clip    (lead_clip),
    .trail_clip   (trail_clip),
    .rec          (rec),
    .rec_push     (rec_push)
  );

  a2c_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (rec_push),
    .push_rec (rec),
    .pop      (pop),
    .head_rec (head_rec),
    .status   (status)
  );

  a2c_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_rec     (head_rec),
    .status       (status),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .op_code      (op_code),
    .run_length   (run_length),
    .end_of_cigar (end_of_cigar)
  );

endmodule

`default_nettype wire
